// ----- rtl/core/dqpd_pkg.sv -----
// dqpd_pkg: shared types, constants and the x4 transition decode for the
// dual quadrature position decoder.
// No dependencies.
`default_nettype none

package dqpd_pkg;

    // fixed field widths
    localparam int PinW       = 2;
    localparam int FieldW     = 16;
    localparam int CfgDataW   = 16;
    localparam int CfgIdxW    = 1;
    localparam int ErrW       = 16;

    // default position register width
    localparam int POSITION_WIDTH_DEF = 16;

    // previous pin state lands in bits 3..2 of the table index
    localparam logic [3:0] HIST_MASK = 4'hc;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MULT_CH0 = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MULT_CH1 = 1'b1;

    // restart opcode
    localparam logic OP_PIN_EVENT = 1'b0;
    localparam logic OP_RESTART   = 1'b1;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_UP   = 2'd1,
        MOVE_DOWN = 2'd2,
        MOVE_ERR  = 2'd3
    } t_move;

    typedef struct packed {
        logic              operation;
        logic [PinW-1:0]   pins_ch0;
        logic [PinW-1:0]   pins_ch1;
    } t_in_beat;

    typedef struct packed {
        logic [FieldW-1:0] position_ch0;
        logic [FieldW-1:0] position_ch1;
        logic [FieldW-1:0] error_count;
    } t_out_beat;

    // x4 transition table, index = {previous, current}
    function automatic t_move move_decode(input logic [PinW-1:0] prev,
                                          input logic [PinW-1:0] cur);
        logic [3:0] idx;
        t_move      mv;
        idx = ({prev, 2'b00} & HIST_MASK) | {2'b00, cur};
        unique case (idx)
            4'd0:    mv = MOVE_NONE;
            4'd1:    mv = MOVE_UP;
            4'd2:    mv = MOVE_DOWN;
            4'd3:    mv = MOVE_ERR;
            4'd4:    mv = MOVE_DOWN;
            4'd5:    mv = MOVE_NONE;
            4'd6:    mv = MOVE_ERR;
            4'd7:    mv = MOVE_UP;
            4'd8:    mv = MOVE_UP;
            4'd9:    mv = MOVE_ERR;
            4'd10:   mv = MOVE_NONE;
            4'd11:   mv = MOVE_DOWN;
            4'd12:   mv = MOVE_ERR;
            4'd13:   mv = MOVE_DOWN;
            4'd14:   mv = MOVE_UP;
            default: mv = MOVE_NONE;
        endcase
        return mv;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dual_quadrature_position_decoder.sv -----
// Two-channel x4 quadrature decoder with positions and a shared error count.
// Depends on dqpd_pkg.
`default_nettype none

// Each input beat carries both channels' sampled A/B lines. The stored pin
// history and the new sample index the x4 transition table combinationally,
// the step multiplier is added or subtracted, and the updated positions and
// error count are registered as the result beat. One beat is accepted every
// clock as long as the result register is empty or its beat is taken in the
// same cycle; o_valid rises in the cycle after accept. A restart beat clears
// positions and error count and loads the pin histories from its sample.
// Both step multipliers reset to 1; the user must write them via the plain
// config port while the block is idle, which the block does not enforce.
// Positions are POSITION_WIDTH bits wide; the result has their low 16 bits.
module dual_quadrature_position_decoder #(
    parameter int POSITION_WIDTH = dqpd_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [dqpd_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire logic [dqpd_pkg::CfgDataW-1:0]     i_cfg_data,
    // sample channel
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire dqpd_pkg::t_in_beat                i_data,
    // result channel
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      dqpd_pkg::t_out_beat               o_data
);
    import dqpd_pkg::*;

    localparam int WideW = (POSITION_WIDTH > FieldW) ? POSITION_WIDTH : FieldW;

    // config registers
    logic [CfgDataW-1:0]       r_mult_ch0;
    logic [CfgDataW-1:0]       r_mult_ch1;

    // decoder state, also the result payload
    logic [PinW-1:0]           r_hist_ch0, n_hist_ch0;
    logic [PinW-1:0]           r_hist_ch1, n_hist_ch1;
    logic [POSITION_WIDTH-1:0] r_pos_ch0, n_pos_ch0;
    logic [POSITION_WIDTH-1:0] r_pos_ch1, n_pos_ch1;
    logic [ErrW-1:0]           r_err, n_err;
    logic                      r_out_valid, n_out_valid;

    logic                      in_acc;
    logic                      out_acc;
    t_move                     move_ch0;
    t_move                     move_ch1;
    logic [WideW-1:0]          mult_wide_ch0;
    logic [WideW-1:0]          mult_wide_ch1;
    logic [POSITION_WIDTH-1:0] step_ch0;
    logic [POSITION_WIDTH-1:0] step_ch1;
    logic [1:0]                err_inc;
    logic [WideW-1:0]          pos_wide_ch0;
    logic [WideW-1:0]          pos_wide_ch1;

    // handshake: take a beat whenever the result slot is empty or frees up this cycle
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    // table decode per channel
    assign move_ch0 = move_decode(r_hist_ch0, i_data.pins_ch0);
    assign move_ch1 = move_decode(r_hist_ch1, i_data.pins_ch1);

    // multipliers fitted to the position width
    assign mult_wide_ch0 = WideW'(r_mult_ch0);
    assign mult_wide_ch1 = WideW'(r_mult_ch1);
    assign step_ch0      = mult_wide_ch0[POSITION_WIDTH-1:0];
    assign step_ch1      = mult_wide_ch1[POSITION_WIDTH-1:0];

    assign err_inc = {1'b0, move_ch0 == MOVE_ERR} + {1'b0, move_ch1 == MOVE_ERR};

    // next state for an accepted beat
    always_comb begin
        n_hist_ch0  = r_hist_ch0;
        n_hist_ch1  = r_hist_ch1;
        n_pos_ch0   = r_pos_ch0;
        n_pos_ch1   = r_pos_ch1;
        n_err       = r_err;
        n_out_valid = r_out_valid && !out_acc;
        if (in_acc) begin
            n_out_valid = 1'b1;
            n_hist_ch0  = i_data.pins_ch0;
            n_hist_ch1  = i_data.pins_ch1;
            if (i_data.operation == OP_RESTART) begin
                n_pos_ch0 = '0;
                n_pos_ch1 = '0;
                n_err     = '0;
            end else begin
                unique case (move_ch0)
                    MOVE_UP:   n_pos_ch0 = r_pos_ch0 + step_ch0;
                    MOVE_DOWN: n_pos_ch0 = r_pos_ch0 - step_ch0;
                    default:   n_pos_ch0 = r_pos_ch0;
                endcase
                unique case (move_ch1)
                    MOVE_UP:   n_pos_ch1 = r_pos_ch1 + step_ch1;
                    MOVE_DOWN: n_pos_ch1 = r_pos_ch1 - step_ch1;
                    default:   n_pos_ch1 = r_pos_ch1;
                endcase
                n_err = r_err + ErrW'(err_inc);
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_ch0 <= CfgDataW'(1);
            r_mult_ch1 <= CfgDataW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MULT_CH0: r_mult_ch0 <= i_cfg_data;
                CFG_MULT_CH1: r_mult_ch1 <= i_cfg_data;
                default:      r_mult_ch0 <= r_mult_ch0;
            endcase
        end
    end

    // decoder state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_ch0  <= '0;
            r_hist_ch1  <= '0;
            r_pos_ch0   <= '0;
            r_pos_ch1   <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist_ch0  <= n_hist_ch0;
            r_hist_ch1  <= n_hist_ch1;
            r_pos_ch0   <= n_pos_ch0;
            r_pos_ch1   <= n_pos_ch1;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // result beat, low 16 bits of each position
    assign pos_wide_ch0        = WideW'(r_pos_ch0);
    assign pos_wide_ch1        = WideW'(r_pos_ch1);
    assign o_valid             = r_out_valid;
    assign o_data.position_ch0 = pos_wide_ch0[FieldW-1:0];
    assign o_data.position_ch1 = pos_wide_ch1[FieldW-1:0];
    assign o_data.error_count  = r_err;

`ifndef SYNTH
    // a restart beat reports all zero counts
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.operation == OP_RESTART |=>
            r_pos_ch0 == '0 && r_pos_ch1 == '0 && r_err == '0)
        else $error("restart did not clear counts");

    // every accepted beat leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    // state holds while no beat is taken
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_err) && $stable(r_pos_ch0) && $stable(r_pos_ch1)
            && $stable(r_hist_ch0) && $stable(r_hist_ch1))
        else $error("decoder state moved without a beat");

    // error count rises by at most two per beat
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.operation == OP_PIN_EVENT |=>
            ErrW'(r_err - $past(r_err)) <= ErrW'(2))
        else $error("error count jumped by more than two");

    // the sample side only stalls behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall)
        else $error("stall without a pending result");
`endif

endmodule

`default_nettype wire

// ----- sim/dqpd_checker.sv -----
// dqpd_checker: watches the sample, result and config ports of the dual
// quadrature decoder, predicts every result beat and compares it field by field.
// Depends on dqpd_pkg.
`default_nettype none

module dqpd_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dqpd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [dqpd_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire dqpd_pkg::t_in_beat            i_in_data,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire dqpd_pkg::t_out_beat           i_out_data,
    output int                                 o_fail_count,
    output int                                 o_outstanding,
    output int                                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import dqpd_pkg::*;

    // predictor copy of the decoder state
    logic [15:0] mult_ch0 = 16'd1;
    logic [15:0] mult_ch1 = 16'd1;
    logic [1:0]  hist_ch0 = '0;
    logic [1:0]  hist_ch1 = '0;
    logic [15:0] pos_ch0  = '0;
    logic [15:0] pos_ch1  = '0;
    logic [15:0] err_total = '0;

    t_out_beat expected_positions[$];
    int        mismatches = 0;
    int        results_checked = 0;

    assign o_fail_count = mismatches;
    assign o_results    = results_checked;

    // rank of a pin state along the gray cycle 00 -> 01 -> 11 -> 10
    function automatic t_move classify_transition(input logic [1:0] was,
                                                  input logic [1:0] now);
        logic [1:0] rank_was;
        logic [1:0] rank_now;
        logic [1:0] delta;
        rank_was = {was[1], ^was};
        rank_now = {now[1], ^now};
        delta    = rank_now - rank_was;
        case (delta)
            2'd0:    return MOVE_NONE;
            2'd1:    return MOVE_UP;
            2'd2:    return MOVE_ERR;
            default: return MOVE_DOWN;
        endcase
    endfunction

    function automatic logic [15:0] move_position(input logic [15:0] pos,
                                                  input t_move mv,
                                                  input logic [15:0] mult);
        if (mv == MOVE_UP)
            return pos + mult;
        else if (mv == MOVE_DOWN)
            return pos - mult;
        return pos;
    endfunction

    // advance the predicted state by one sample beat
    function automatic t_out_beat predict_positions(input t_in_beat s);
        t_move     mv0;
        t_move     mv1;
        t_out_beat r;
        if (s.operation == OP_RESTART) begin
            pos_ch0   = '0;
            pos_ch1   = '0;
            err_total = '0;
        end else begin
            mv0 = classify_transition(hist_ch0, s.pins_ch0);
            mv1 = classify_transition(hist_ch1, s.pins_ch1);
            pos_ch0 = move_position(pos_ch0, mv0, mult_ch0);
            pos_ch1 = move_position(pos_ch1, mv1, mult_ch1);
            if (mv0 == MOVE_ERR)
                err_total = err_total + 16'd1;
            if (mv1 == MOVE_ERR)
                err_total = err_total + 16'd1;
        end
        hist_ch0 = s.pins_ch0;
        hist_ch1 = s.pins_ch1;
        r.position_ch0 = pos_ch0;
        r.position_ch1 = pos_ch1;
        r.error_count  = err_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // result compare, then sample prediction, then register writes
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            mult_ch0  = 16'd1;
            mult_ch1  = 16'd1;
            hist_ch0  = '0;
            hist_ch1  = '0;
            pos_ch0   = '0;
            pos_ch1   = '0;
            err_total = '0;
            expected_positions.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_positions.size() == 0) begin
                    report_mismatch($sformatf("result beat %0h with nothing pending",
                                              i_out_data));
                end else begin
                    want = expected_positions.pop_front();
                    if (i_out_data.position_ch0 !== want.position_ch0)
                        report_mismatch($sformatf("position_ch0 want %h got %h",
                                                  want.position_ch0,
                                                  i_out_data.position_ch0));
                    if (i_out_data.position_ch1 !== want.position_ch1)
                        report_mismatch($sformatf("position_ch1 want %h got %h",
                                                  want.position_ch1,
                                                  i_out_data.position_ch1));
                    if (i_out_data.error_count !== want.error_count)
                        report_mismatch($sformatf("error_count want %h got %h",
                                                  want.error_count,
                                                  i_out_data.error_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_positions.push_back(predict_positions(i_in_data));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MULT_CH0: mult_ch0 = i_cfg_data;
                    CFG_MULT_CH1: mult_ch1 = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= expected_positions.size();
    end

endmodule

`default_nettype wire

// ----- sim/dual_quadrature_position_decoder_test.sv -----
// dual_quadrature_position_decoder_test: reset, directed and random pin
// traffic with random gaps and stalls, multiplier changes between phases.
// Depends on dqpd_pkg, dual_quadrature_position_decoder and dqpd_checker.
`default_nettype none

module dual_quadrature_position_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dqpd_pkg::*;

    // pin walk visiting every ordered pair of states once, state k at bits 2k+1:2k
    localparam logic [33:0] PIN_WALK =
        34'b00_11_11_10_10_11_01_10_01_01_11_00_10_00_01_00_00;
    localparam int PHASE_BEATS = 220;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx  = CFG_MULT_CH0;
    logic [CfgDataW-1:0]  i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    t_in_beat             i_data     = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    t_out_beat            o_data;

    int   fail_count;
    int   outstanding;
    int   results_seen;
    bit   steady         = 1'b0;
    int   beats_sent     = 0;
    int   restarts_sent  = 0;
    int   settings_used  = 1;
    logic [1:0] track_ch0 = '0;
    logic [1:0] track_ch1 = '0;

    dual_quadrature_position_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    dqpd_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_data    (o_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_results     (results_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    // mostly legal quadrature steps, now and then a double change
    function automatic logic [1:0] walk_pins(input logic [1:0] s);
        int r;
        r = $urandom_range(0, 99);
        if (r < 42)
            return {s[0], ~s[1]};
        else if (r < 84)
            return {~s[0], s[1]};
        else if (r < 94)
            return s;
        return s ^ 2'b11;
    endfunction

    // present one sample beat after a random gap, return once it is taken
    task automatic send_sample(input logic op, input logic [1:0] p0,
                               input logic [1:0] p1);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data.operation <= op;
        i_data.pins_ch0  <= p0;
        i_data.pins_ch1  <= p1;
        do @(posedge i_clk); while (o_stall);
        track_ch0 = p0;
        track_ch1 = p1;
        beats_sent++;
        if (op == OP_RESTART)
            restarts_sent++;
    endtask

    // hold off until every pending result beat has been taken
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // write both multipliers, block is idle
    task automatic set_multipliers(input logic [15:0] m0, input logic [15:0] m1);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MULT_CH0;
        i_cfg_data <= m0;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MULT_CH1;
        i_cfg_data <= m1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        logic [1:0] p0;
        logic [1:0] p1;
        int         r;
        for (int k = 0; k < count; k++) begin
            if ((k % 40) == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_sample(OP_RESTART, 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)));
            end else begin
                if (r < 15) begin
                    p0 = 2'($urandom_range(0, 3));
                    p1 = 2'($urandom_range(0, 3));
                end else begin
                    p0 = walk_pins(track_ch0);
                    p1 = walk_pins(track_ch1);
                end
                send_sample(OP_PIN_EVENT, p0, p1);
            end
        end
        steady = 1'b0;
    endtask

    // result side: random stall before each beat
    initial begin
        int hold;
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: hold, double error from reset, restarts, full transition walk
        send_sample(OP_PIN_EVENT, 2'd0, 2'd0);
        send_sample(OP_PIN_EVENT, 2'd3, 2'd3);
        send_sample(OP_RESTART, 2'd2, 2'd1);
        send_sample(OP_PIN_EVENT, 2'd1, 2'd2);
        send_sample(OP_RESTART, 2'd0, 2'd0);
        for (int k = 1; k <= 16; k++)
            send_sample(OP_PIN_EVENT, PIN_WALK[2*k +: 2], PIN_WALK[2*(16-k) +: 2]);
        drain();

        // random phases over extreme and random multipliers
        set_multipliers(16'hffff, 16'h0000);
        random_phase(PHASE_BEATS);
        drain();
        set_multipliers(16'h0000, 16'hffff);
        random_phase(PHASE_BEATS);
        drain();
        set_multipliers(16'h8000, 16'h7fff);
        random_phase(PHASE_BEATS);
        drain();
        set_multipliers(16'($urandom), 16'($urandom));
        random_phase(PHASE_BEATS);
        drain();
        set_multipliers(16'h0001, 16'h0001);
        random_phase(PHASE_BEATS);
        drain();

        $display("summary: %0d sample beats, %0d restarts, %0d multiplier settings",
                 beats_sent, restarts_sent, settings_used);
        $display("summary: %0d result beats compared, %0d mismatches",
                 results_seen, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
